### src/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the pick-and-place stack sequencer.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Position stack depth and the widths that follow from it.
	localparam int DEPTH = 10;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int COORD_W = 16;
	localparam int CFG_IDX_W = 3;

	// Command codes.
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2,
		OP_CLEAR = 2'd3
	} pps_op_t;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SURFACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUND_SURFACE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_X         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_Y         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_X        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_Y        = 3'd6;

	// Sequencer state code shown while no run is in progress.
	localparam logic [2:0] SEQ_IDLE_CODE = 3'd0;

	typedef struct packed {
		pps_op_t              opcode;
		logic [COORD_W-1:0]   block_x;
		logic [COORD_W-1:0]   block_y;
		logic                 arm_moving;
		logic [COORD_W-1:0]   lift_position;
	} pps_cmd_t;

	typedef struct packed {
		logic                 move_xy_valid;
		logic [COORD_W-1:0]   target_x;
		logic [COORD_W-1:0]   target_y;
		logic                 move_z_valid;
		logic [COORD_W-1:0]   target_z;
		logic                 valve_write;
		logic                 valve_on;
		logic [2:0]           fsm_state;
		logic                 run_active;
		logic [3:0]           stack_count;
		logic                 push_dropped;
	} pps_res_t;

	typedef struct packed {
		logic [COORD_W-1:0]   block_height;
		logic [COORD_W-1:0]   target_surface;
		logic [COORD_W-1:0]   ground_surface;
		logic [COORD_W-1:0]   home_x;
		logic [COORD_W-1:0]   home_y;
		logic [COORD_W-1:0]   stack_x;
		logic [COORD_W-1:0]   stack_y;
	} pps_cfg_t;

	// Stack operations requested by the sequencer.
	typedef struct packed {
		logic                 push;
		logic                 pop;
		logic                 clear;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
	} pps_stk_ctl_t;

	// Stack status seen by the sequencer.
	typedef struct packed {
		logic [CNT_W-1:0]     count_next;
		logic                 full;
		logic                 empty;
		logic [COORD_W-1:0]   top_x;
		logic [COORD_W-1:0]   top_y;
	} pps_stk_sts_t;

endpackage
`default_nettype wire

### src/pps_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_cfg_regs
// Configuration register file: heights, surfaces and XY positions.
// ----------------------------------------------------------------------------
module pps_cfg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            wr_en,
	input  wire [pps_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire [pps_pkg::COORD_W-1:0]     wr_data,
	output pps_pkg::pps_cfg_t              cfg
);
	import pps_pkg::*;

	pps_cfg_t cfg_q;

	// Write the addressed register; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BLOCK_HEIGHT:   cfg_q.block_height   <= wr_data;
				REG_TARGET_SURFACE: cfg_q.target_surface <= wr_data;
				REG_GROUND_SURFACE: cfg_q.ground_surface <= wr_data;
				REG_HOME_X:         cfg_q.home_x         <= wr_data;
				REG_HOME_Y:         cfg_q.home_y         <= wr_data;
				REG_STACK_X:        cfg_q.stack_x        <= wr_data;
				REG_STACK_Y:        cfg_q.stack_y        <= wr_data;
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### src/pps_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_stack
// LIFO of block positions with a fill count; pushes past DEPTH are refused.
// ----------------------------------------------------------------------------
module pps_stack (
	input  wire                       clk,
	input  wire                       arst_n,
	input  pps_pkg::pps_stk_ctl_t     ctl,
	output pps_pkg::pps_stk_sts_t     sts
);
	import pps_pkg::*;

	logic [2*COORD_W-1:0] mem_q [DEPTH];
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic [IDX_W-1:0]     top_idx;
	logic [IDX_W-1:0]     wr_idx;
	logic                 full;
	logic                 empty;
	logic [CNT_W-1:0]     count_dec;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign count_dec = count_q - CNT_W'(1);
	assign top_idx   = empty ? '0 : count_dec[IDX_W-1:0];
	assign wr_idx    = full ? '0 : count_q[IDX_W-1:0];

	// Next fill count after the requested operation.
	always_comb begin
		count_next = count_q;
		if (ctl.clear) begin
			count_next = '0;
		end else if (ctl.push && !full) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.pop && !empty) begin
			count_next = count_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Entry storage, written on an accepted push.
	always_ff @(posedge clk) begin
		if (ctl.push && !full && !ctl.clear) begin
			mem_q[wr_idx] <= {ctl.x, ctl.y};
		end
	end

	assign sts.count_next = count_next;
	assign sts.full       = full;
	assign sts.empty      = empty;
	assign sts.top_x      = mem_q[top_idx][2*COORD_W-1:COORD_W];
	assign sts.top_y      = mem_q[top_idx][COORD_W-1:0];

endmodule
`default_nettype wire

### src/pick_place_stack_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pick_place_stack_sequencer
// Position stack and seven-state pick-and-place sequencer issuing XY, Z and
// vacuum valve commands, one result per command.
// ----------------------------------------------------------------------------
//  channel  signals                              direction  purpose
//  cmd      cmd_valid / cmd_ready / cmd          in         push, start, tick, clear
//  res      res_valid / res_ready / res          out        one result per command
//  cfg      cfg_valid / cfg_ready / cfg_index,   in         register writes
//           cfg_data
//
// A command is registered on transfer and resolved into the result register
// once that register is free: one command per cycle while results are taken,
// with the multiplier blocks_done * block_height on the longest combinational path.
// Reset clears the stack count, the sequencer and the configuration registers.
// A stalled result holds the result register; the input register still takes
// one more command, then cmd_ready drops until the result is taken. cfg_ready is high.
// ----------------------------------------------------------------------------
module pick_place_stack_sequencer (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cmd_valid,
	output logic                           cmd_ready,
	input  pps_pkg::pps_cmd_t              cmd,
	output logic                           res_valid,
	input  wire                            res_ready,
	output pps_pkg::pps_res_t              res,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [pps_pkg::COORD_W-1:0]     cfg_data
);
	import pps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE     = SEQ_IDLE_CODE,
		S_NEXT     = 3'd1,
		S_PICK     = 3'd2,
		S_PICKED   = 3'd3,
		S_CENTER   = 3'd4,
		S_RELEASE  = 3'd5,
		S_RELEASED = 3'd6
	} seq_state_t;

	localparam int PROD_W = 8 + COORD_W;
	localparam int SUB_W  = PROD_W + 1;

	pps_cfg_t     cfg;
	pps_stk_ctl_t stk_ctl;
	pps_stk_sts_t stk_sts;

	pps_cmd_t     cmd_s1;
	logic         valid_s1;
	logic         advance;

	seq_state_t   state_q, state_next;
	logic         running_q, running_next;
	logic [7:0]   done_q, done_next;
	logic         res_valid_q;
	pps_res_t     res_q, res_next;

	logic [PROD_W-1:0]  done_prod;
	logic               z_ground;
	logic               z_use_done;
	logic               z_two;
	logic [COORD_W-1:0] z_surface;
	logic [SUB_W-1:0]   z_sub;
	logic [SUB_W-1:0]   z_diff;
	logic [COORD_W-1:0] z_value;
	logic               stepping;

	pps_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pps_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stk_ctl),
		.sts    (stk_sts)
	);

	assign cfg_ready = 1'b1;

	// Handshake: the input stage moves on whenever the result register is free.
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	// Z target selection depends on the current state only.
	always_comb begin
		z_ground   = 1'b0;
		z_use_done = 1'b1;
		z_two      = 1'b1;
		unique case (state_q)
			S_NEXT: begin
				z_ground   = 1'b1;
				z_use_done = 1'b0;
			end
			S_PICK: begin
				z_ground   = 1'b1;
				z_use_done = 1'b0;
				z_two      = 1'b0;
			end
			S_RELEASE: begin
				z_two = 1'b0;
			end
			default: begin
				z_two = 1'b1;
			end
		endcase
	end

	// Surface minus a multiple of the block height, clamped at zero.
	assign done_prod = PROD_W'(done_q) * PROD_W'(cfg.block_height);
	assign z_surface = z_ground ? cfg.ground_surface : cfg.target_surface;
	assign z_sub     = (z_use_done ? SUB_W'(done_prod) : '0)
	                 + (z_two ? SUB_W'({cfg.block_height, 1'b0}) : SUB_W'(cfg.block_height));
	assign z_diff    = SUB_W'(z_surface) - z_sub;
	assign z_value   = (SUB_W'(z_surface) > z_sub) ? z_diff[COORD_W-1:0] : '0;

	assign stepping = advance && (cmd_s1.opcode == OP_TICK);

	// Stack requests for the command in the input stage.
	always_comb begin
		stk_ctl.push  = advance && (cmd_s1.opcode == OP_PUSH);
		stk_ctl.clear = advance && (cmd_s1.opcode == OP_CLEAR);
		stk_ctl.pop   = stepping && (state_q == S_NEXT) && !cmd_s1.arm_moving
		              && !stk_sts.empty;
		stk_ctl.x     = cmd_s1.block_x;
		stk_ctl.y     = cmd_s1.block_y;
	end

	// Sequencer step and result assembly.
	always_comb begin
		state_next   = state_q;
		running_next = running_q;
		done_next    = done_q;
		res_next     = '0;

		unique case (cmd_s1.opcode)
			OP_PUSH: begin
				res_next.push_dropped = stk_sts.full;
			end
			OP_START: begin
				done_next    = '0;
				running_next = 1'b1;
				state_next   = S_NEXT;
			end
			OP_CLEAR: begin
				state_next = state_q;
			end
			OP_TICK: begin
				unique case (state_q)
					S_IDLE: begin
						state_next = S_IDLE;
					end
					S_NEXT: begin
						if (!cmd_s1.arm_moving) begin
							res_next.move_xy_valid = 1'b1;
							if (!stk_sts.empty) begin
								res_next.target_x     = stk_sts.top_x;
								res_next.target_y     = stk_sts.top_y;
								res_next.move_z_valid = 1'b1;
								res_next.target_z     = z_value;
								state_next            = S_PICK;
							end else begin
								res_next.target_x = cfg.home_x;
								res_next.target_y = cfg.home_y;
								running_next      = 1'b0;
								state_next        = S_IDLE;
							end
						end
					end
					S_PICK: begin
						if (!cmd_s1.arm_moving) begin
							res_next.move_z_valid = 1'b1;
							res_next.target_z     = z_value;
							state_next            = S_PICKED;
						end
					end
					S_PICKED: begin
						if (!cmd_s1.arm_moving) begin
							res_next.valve_write  = 1'b1;
							res_next.valve_on     = 1'b1;
							res_next.move_z_valid = 1'b1;
							res_next.target_z     = z_value;
							state_next            = S_CENTER;
						end
					end
					S_CENTER: begin
						if (PROD_W'(cmd_s1.lift_position) > done_prod) begin
							res_next.move_xy_valid = 1'b1;
							res_next.target_x      = cfg.stack_x;
							res_next.target_y      = cfg.stack_y;
							state_next             = S_RELEASE;
						end
					end
					S_RELEASE: begin
						if (!cmd_s1.arm_moving) begin
							res_next.move_z_valid = 1'b1;
							res_next.target_z     = z_value;
							state_next            = S_RELEASED;
						end
					end
					S_RELEASED: begin
						if (!cmd_s1.arm_moving) begin
							res_next.valve_write  = 1'b1;
							res_next.move_z_valid = 1'b1;
							res_next.target_z     = z_value;
							state_next            = S_NEXT;
							done_next             = done_q + 8'd1;
						end
					end
					default: begin
						state_next = S_IDLE;
					end
				endcase
			end
			default: begin
				state_next = state_q;
			end
		endcase

		res_next.fsm_state   = state_next;
		res_next.run_active  = running_next;
		res_next.stack_count = 4'(stk_sts.count_next);
	end

	// Sequencer state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			done_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q   <= state_next;
				running_q <= running_next;
				done_q    <= done_next;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

### src/pps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the pick-and-place stack sequencer, bound to the top.
// ----------------------------------------------------------------------------
module pps_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                res_valid,
	input wire                res_ready,
	input pps_pkg::pps_res_t  res
);
	import pps_pkg::*;

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// The stack never reports more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (int'(res.stack_count) <= DEPTH))
		else $error("stack count above depth");

	// A dropped push only happens with a full stack.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.push_dropped |-> (int'(res.stack_count) == DEPTH))
		else $error("push dropped with room left");

	// Every valve command comes with a Z move.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.valve_write |-> res.move_z_valid)
		else $error("valve command without Z move");

	// A run is active exactly while the sequencer is out of idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.fsm_state == SEQ_IDLE_CODE) == !res.run_active))
		else $error("run flag disagrees with sequencer state");

endmodule

bind pick_place_stack_sequencer pps_checker u_pps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire

### verif/pick_place_stack_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pick_place_stack_sequencer_test
// Self-checking bench for the pick-and-place stack sequencer. Commands go in
// through a valid/ready channel with random gaps, and results come back through
// one with random stalls. A behavioral copy of the sequencer predicts every
// result but those of typed scripted rows. A short scripted part comes first,
// then random pick-and-place runs under several register settings.
// ----------------------------------------------------------------------------
module pick_place_stack_sequencer_test;
	import pps_pkg::*;

	localparam int NUM_REGS = 7;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int LONG_HOLD_AFTER = 300;
	localparam int RUN_TICK_LIMIT = 80;
	localparam int PHASE_ITEMS = 230;

	// Sequencer state codes as they appear on fsm_state.
	typedef enum logic [2:0] {
		SEQ_IDLE     = 3'd0,
		SEQ_NEXT     = 3'd1,
		SEQ_PICK     = 3'd2,
		SEQ_PICKED   = 3'd3,
		SEQ_CENTER   = 3'd4,
		SEQ_RELEASE  = 3'd5,
		SEQ_RELEASED = 3'd6
	} seq_t;

	// One scripted step: the command and, where it is obvious, the result.
	typedef struct packed {
		pps_cmd_t cmd;
		logic     typed;
		pps_res_t want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_ready;
	pps_cmd_t             cmd;
	logic                 res_valid;
	logic                 res_ready;
	pps_res_t             res;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	// Behavioral copy of the block.
	logic [15:0] pos_x [DEPTH];
	logic [15:0] pos_y [DEPTH];
	int          pos_count;
	seq_t        seq_now;
	logic        run_on;
	logic [7:0]  placed_count;
	pps_cfg_t    regs;

	pps_res_t    arm_cmd_queue [$];
	script_row_t script [$];
	int          mismatches;
	int          items_sent;
	int          results_taken;
	bit          steady_flow;

	pick_place_stack_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Surface distance minus a number of block heights, never below zero.
	function automatic logic [15:0] z_below(logic [15:0] surface, int unsigned layers);
		longint unsigned drop;
		drop = longint'(layers) * regs.block_height;
		return (surface > drop) ? 16'(surface - drop) : 16'd0;
	endfunction

	// Advance the behavioral copy by one command and return its result.
	function automatic pps_res_t step_sequencer(pps_cmd_t c);
		pps_res_t r;
		r = '0;
		case (c.opcode)
			OP_PUSH: begin
				if (pos_count < DEPTH) begin
					pos_x[pos_count] = c.block_x;
					pos_y[pos_count] = c.block_y;
					pos_count++;
				end else begin
					r.push_dropped = 1'b1;
				end
			end
			OP_START: begin
				placed_count = '0;
				run_on = 1'b1;
				seq_now = SEQ_NEXT;
			end
			OP_CLEAR: begin
				pos_count = 0;
			end
			default: begin
				case (seq_now)
					SEQ_IDLE: ;
					SEQ_NEXT: begin
						if (!c.arm_moving) begin
							r.move_xy_valid = 1'b1;
							if (pos_count > 0) begin
								pos_count--;
								r.target_x = pos_x[pos_count];
								r.target_y = pos_y[pos_count];
								r.move_z_valid = 1'b1;
								r.target_z = z_below(regs.ground_surface, 2);
								seq_now = SEQ_PICK;
							end else begin
								// Nothing left to pick: go home and end the run.
								r.target_x = regs.home_x;
								r.target_y = regs.home_y;
								run_on = 1'b0;
								seq_now = SEQ_IDLE;
							end
						end
					end
					SEQ_PICK: begin
						if (!c.arm_moving) begin
							r.move_z_valid = 1'b1;
							r.target_z = z_below(regs.ground_surface, 1);
							seq_now = SEQ_PICKED;
						end
					end
					SEQ_PICKED: begin
						if (!c.arm_moving) begin
							r.valve_write = 1'b1;
							r.valve_on = 1'b1;
							r.move_z_valid = 1'b1;
							r.target_z = z_below(regs.target_surface, placed_count + 2);
							seq_now = SEQ_CENTER;
						end
					end
					SEQ_CENTER: begin
						// The lift must clear the stack before the arm moves over it.
						if (longint'(c.lift_position) >
								longint'(placed_count) * regs.block_height) begin
							r.move_xy_valid = 1'b1;
							r.target_x = regs.stack_x;
							r.target_y = regs.stack_y;
							seq_now = SEQ_RELEASE;
						end
					end
					SEQ_RELEASE: begin
						if (!c.arm_moving) begin
							r.move_z_valid = 1'b1;
							r.target_z = z_below(regs.target_surface, placed_count + 1);
							seq_now = SEQ_RELEASED;
						end
					end
					SEQ_RELEASED: begin
						if (!c.arm_moving) begin
							r.valve_write = 1'b1;
							r.move_z_valid = 1'b1;
							r.target_z = z_below(regs.target_surface, placed_count + 2);
							seq_now = SEQ_NEXT;
							placed_count = placed_count + 8'd1;
						end
					end
					default: seq_now = SEQ_IDLE;
				endcase
			end
		endcase
		r.fsm_state = seq_now;
		r.run_active = run_on;
		r.stack_count = 4'(pos_count);
		return r;
	endfunction

	function automatic pps_cmd_t rand_cmd(pps_op_t op);
		pps_cmd_t c;
		c.opcode = op;
		c.block_x = 16'($urandom);
		c.block_y = 16'($urandom);
		c.arm_moving = 1'($urandom_range(0, 1));
		c.lift_position = 16'($urandom);
		return c;
	endfunction

	function automatic pps_cmd_t make_cmd(pps_op_t op, logic [15:0] x, logic [15:0] y,
			logic moving, logic [15:0] lift);
		pps_cmd_t c;
		c.opcode = op;
		c.block_x = x;
		c.block_y = y;
		c.arm_moving = moving;
		c.lift_position = lift;
		return c;
	endfunction

	// Append a scripted step; typed rows carry only state, run, count and drop.
	function automatic void add_row(pps_cmd_t c, logic typed, seq_t st, logic run,
			logic [3:0] count, logic dropped);
		script_row_t row;
		row.cmd = c;
		row.typed = typed;
		row.want = '0;
		row.want.fsm_state = st;
		row.want.run_active = run;
		row.want.stack_count = count;
		row.want.push_dropped = dropped;
		script.push_back(row);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one command and predict its result once the transfer happens.
	// Called at the edge of the previous transfer, so valid is only lowered
	// when a gap follows.
	task automatic send_cmd(input pps_cmd_t c, input logic typed = 1'b0,
			input pps_res_t want = '0);
		int gap;
		pps_res_t predicted;
		gap = steady_flow ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		predicted = step_sequencer(c);
		arm_cmd_queue.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// Stop offering commands and let every outstanding result come back.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (arm_cmd_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all registers back to back, then take the new setting.
	task automatic load_regs(input pps_cfg_t v);
		logic [CFG_IDX_W-1:0] order [NUM_REGS];
		logic [15:0] vals [NUM_REGS];
		order = '{REG_BLOCK_HEIGHT, REG_TARGET_SURFACE, REG_GROUND_SURFACE,
			REG_HOME_X, REG_HOME_Y, REG_STACK_X, REG_STACK_Y};
		vals = '{v.block_height, v.target_surface, v.ground_surface,
			v.home_x, v.home_y, v.stack_x, v.stack_y};
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		regs = v;
	endtask

	// A stray command of any kind, now and then.
	task automatic maybe_noise();
		if ($urandom_range(0, 11) == 0)
			send_cmd(rand_cmd(pps_op_t'($urandom_range(0, 3))));
	endtask

	// One pick-and-place run: optional clear, pushes, start, ticks until idle or the tick limit.
	task automatic random_run();
		int pushes;
		int ticks;
		pps_cmd_t c;
		steady_flow = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 3) == 0)
			send_cmd(rand_cmd(OP_CLEAR));
		pushes = ($urandom_range(0, 4) == 0) ? DEPTH + 2 : $urandom_range(0, DEPTH);
		for (int i = 0; i < pushes; i++) begin
			maybe_noise();
			send_cmd(rand_cmd(OP_PUSH));
		end
		send_cmd(rand_cmd(OP_START));
		ticks = 0;
		while (seq_now != SEQ_IDLE && ticks < RUN_TICK_LIMIT) begin
			maybe_noise();
			c = rand_cmd(OP_TICK);
			c.arm_moving = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				c.lift_position = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			send_cmd(c);
			ticks++;
		end
	endtask

	// Command side: reset, scripted steps, random runs, verdict.
	initial begin : stimulus
		pps_cfg_t setting;
		int phase_end;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		mismatches = 0;
		items_sent = 0;
		results_taken = 0;
		steady_flow = 1'b0;
		pos_count = 0;
		seq_now = SEQ_IDLE;
		run_on = 1'b0;
		placed_count = '0;
		regs = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ground depth below two block heights, so the first pick clamps at zero.
		setting.block_height = 16'd100;
		setting.target_surface = 16'd1000;
		setting.ground_surface = 16'd150;
		setting.home_x = 16'h1111;
		setting.home_y = 16'h2222;
		setting.stack_x = 16'hFFFF;
		setting.stack_y = 16'h0000;
		load_regs(setting);

		// A tick right after reset does nothing; fill the stack past full.
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'hFFFF), 1, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_PUSH, 16'hFFFF, 16'h0000, 1'b0, 16'h0000), 1, SEQ_IDLE, 0, 1, 0);
		add_row(make_cmd(OP_PUSH, 16'h0000, 16'hFFFF, 1'b1, 16'hFFFF), 1, SEQ_IDLE, 0, 2, 0);
		for (int i = 3; i <= DEPTH; i++)
			add_row(make_cmd(OP_PUSH, 16'(i * 16'h1357), 16'(i * 16'h2468), 1'b0,
				16'h0000), 1, SEQ_IDLE, 0, 4'(i), 0);
		add_row(make_cmd(OP_PUSH, 16'h0A0A, 16'h0B0B, 1'b0, 16'h0000), 1, SEQ_IDLE, 0,
			4'(DEPTH), 1);
		add_row(make_cmd(OP_CLEAR, 16'h0000, 16'h0000, 1'b0, 16'h0000), 1, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000), 1, SEQ_IDLE, 0, 1, 0);
		add_row(make_cmd(OP_START, 16'h0000, 16'h0000, 1'b0, 16'h0000), 1, SEQ_NEXT, 1, 1, 0);
		// One full placement, with a moving arm and a low lift holding it back.
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b1, 16'h0000), 0, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000), 0, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000), 0, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000), 0, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000), 0, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b1, 16'hFFFF), 0, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'hFFFF), 0, SEQ_IDLE, 0, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'hFFFF), 0, SEQ_IDLE, 0, 0, 0);
		// A start during a run restarts it; the empty stack then sends the arm home.
		add_row(make_cmd(OP_START, 16'h0000, 16'h0000, 1'b0, 16'h0000), 1, SEQ_NEXT, 1, 0, 0);
		add_row(make_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000), 0, SEQ_IDLE, 0, 0, 0);

		foreach (script[i])
			send_cmd(script[i].cmd, script[i].typed, script[i].want);
		wait_idle();

		// Random runs under all-zero, all-ones and random register settings.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: setting = '0;
				1: setting = '1;
				default: begin
					setting.block_height = ($urandom_range(0, 3) == 0) ?
						16'($urandom) : 16'($urandom_range(0, 400));
					setting.target_surface = 16'($urandom);
					setting.ground_surface = 16'($urandom);
					setting.home_x = 16'($urandom);
					setting.home_y = 16'($urandom);
					setting.stack_x = 16'($urandom);
					setting.stack_y = 16'($urandom);
				end
			endcase
			load_regs(setting);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				random_run();
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Result side: random stalls, one long hold-off to back the block up.
	initial begin : result_side
		int stall;
		bit long_hold_done;
		pps_res_t want;
		res_ready <= 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && results_taken >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				res_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = steady_flow ? 0 : $urandom_range(0, 5);
				if (stall > 0) begin
					res_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			results_taken++;

			// Compare the transfer with the oldest prediction.
			if (arm_cmd_queue.size() == 0) begin
				$display("%0t: result expected none, got %h", $time, res);
				mismatches++;
			end else begin
				want = arm_cmd_queue.pop_front();
				check_field("move_xy_valid", 16'(want.move_xy_valid), 16'(res.move_xy_valid));
				check_field("target_x", want.target_x, res.target_x);
				check_field("target_y", want.target_y, res.target_y);
				check_field("move_z_valid", 16'(want.move_z_valid), 16'(res.move_z_valid));
				check_field("target_z", want.target_z, res.target_z);
				check_field("valve_write", 16'(want.valve_write), 16'(res.valve_write));
				check_field("valve_on", 16'(want.valve_on), 16'(res.valve_on));
				check_field("fsm_state", 16'(want.fsm_state), 16'(res.fsm_state));
				check_field("run_active", 16'(want.run_active), 16'(res.run_active));
				check_field("stack_count", 16'(want.stack_count), 16'(res.stack_count));
				check_field("push_dropped", 16'(want.push_dropped), 16'(res.push_dropped));
			end
		end
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#3_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time, arm_cmd_queue.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
